/* rtl/core/pmlc_pkg.sv */
// shared types and constants for the ppp/mpls l3 classifier
`default_nettype none

package pmlc_pkg;

  localparam int unsigned LenBits     = 16;
  localparam int unsigned IpHdrBytes  = 20;
  localparam int unsigned LabelBytes  = 4;
  localparam int unsigned CfgW        = 8;
  localparam int unsigned HdrW        = 16;
  localparam int unsigned PosW        = LenBits;
  localparam int unsigned OffW        = LenBits + 1;
  localparam int unsigned SumW        = LenBits + 2;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  localparam logic [15:0] ProtoMpls = 16'h0281;
  localparam logic [15:0] ProtoIpv4 = 16'h0021;
  localparam logic [15:0] ProtoIpv6 = 16'h0057;

  localparam logic [CfgW-1:0] LinkHdrReset  = 8'd4;
  localparam logic [CfgW-1:0] EncapHdrReset = 8'd0;

  typedef enum logic [0:0] {
    CfgLinkHdr  = 1'b0,
    CfgEncapHdr = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ErrNone        = 3'd0,
    ErrNonIp       = 3'd1,
    ErrTruncLabels = 3'd2,
    ErrNoIpMpls    = 3'd3,
    ErrNoIpEncap   = 3'd4,
    ErrBadEncapVer = 3'd5,
    ErrRunt        = 3'd6
  } err_e;

  typedef enum logic [0:0] {
    KindIpv4 = 1'b0,
    KindIpv6 = 1'b1
  } l3_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic [0:0]      l3_kind;
    logic [HdrW-1:0] header_bytes;
    logic [2:0]      error_code;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/pmlc_if.sv */
// valid/ready channel interfaces for byte input and result output
`default_nettype none

interface pmlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pmlc_out_if;
  logic        valid;
  logic        ready;
  logic [0:0]  l3_kind;
  logic [15:0] header_bytes;
  logic [2:0]  error_code;

  modport source (output valid, output l3_kind, output header_bytes, output error_code,
                  input ready);
  modport sink   (input valid, input l3_kind, input header_bytes, input error_code,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/pmlc_in_stage.sv */
// input register stage for packet bytes
`default_nettype none

module pmlc_in_stage (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pmlc_in_if.sink          pkt_in,
  input  wire logic        advance_i,
  output pmlc_pkg::beat_t  beat_o,
  output logic             beat_valid_o
);

  logic            valid_q, valid_d;
  pmlc_pkg::beat_t beat_q;
  logic            load;

  assign pkt_in.ready = !valid_q || advance_i;
  assign load         = pkt_in.valid && pkt_in.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q.data_byte <= pkt_in.data_byte;
      beat_q.last_byte <= pkt_in.last_byte;
    end
  end

  assign beat_o       = beat_q;
  assign beat_valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/core/pmlc_parse.sv */
// per-packet header tracking and end-of-packet classification
`default_nettype none

module pmlc_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire pmlc_pkg::beat_t             beat_i,
  input  wire logic [pmlc_pkg::CfgW-1:0]   link_hdr_i,
  input  wire logic [pmlc_pkg::CfgW-1:0]   encap_hdr_i,
  output logic                             res_valid_o,
  output pmlc_pkg::result_t                res_o
);

  logic [pmlc_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]               proto_q, proto_d;
  logic                      done_q, done_d;
  logic [pmlc_pkg::OffW-1:0] end_q, end_d;
  logic [3:0]                nib_q, nib_d;

  logic                      examine;
  logic [pmlc_pkg::OffW-1:0] pos_ext;
  logic [pmlc_pkg::OffW-1:0] link_ext;
  logic [pmlc_pkg::OffW-1:0] t2;
  logic [1:0]                rel;
  logic                      mpls_q;
  logic [pmlc_pkg::OffW-1:0] len;
  logic [pmlc_pkg::SumW-1:0] end_need;
  logic [pmlc_pkg::SumW-1:0] t2_need;
  logic [pmlc_pkg::SumW-1:0] len_ext;
  logic                      ver_ok;
  logic                      ver_kind;

  assign examine  = pos_q != pmlc_pkg::PosMax;
  assign pos_ext  = {1'b0, pos_q};
  assign link_ext = pmlc_pkg::OffW'(link_hdr_i);
  assign t2       = link_ext + pmlc_pkg::OffW'(encap_hdr_i);
  assign rel      = pos_q[1:0] - link_hdr_i[1:0];
  assign mpls_q   = proto_q == pmlc_pkg::ProtoMpls;

  // byte examination
  always_comb begin
    proto_d = proto_q;
    done_d  = done_q;
    end_d   = end_q;
    nib_d   = nib_q;
    if (examine) begin
      if (pos_ext == pmlc_pkg::OffW'(2) || pos_ext == pmlc_pkg::OffW'(3)) begin
        proto_d = {proto_q[7:0], beat_i.data_byte};
      end
      if (!done_q && pos_ext >= link_ext && rel == 2'd2 && beat_i.data_byte[0]) begin
        done_d = 1'b1;
        end_d  = pos_ext + pmlc_pkg::OffW'(pmlc_pkg::LabelBytes - 2);
      end
      if (pos_ext == t2 && (pos_ext < pmlc_pkg::OffW'(4) || !mpls_q)) begin
        nib_d = beat_i.data_byte[7:4];
      end
      if (done_q && mpls_q && pos_ext >= pmlc_pkg::OffW'(4) && pos_ext == end_q) begin
        nib_d = beat_i.data_byte[7:4];
      end
    end
  end

  // classification at the last beat
  assign len      = pos_ext + pmlc_pkg::OffW'(1);
  assign len_ext  = {1'b0, len};
  assign end_need = {1'b0, end_d} + pmlc_pkg::SumW'(pmlc_pkg::IpHdrBytes);
  assign t2_need  = {1'b0, t2} + pmlc_pkg::SumW'(pmlc_pkg::IpHdrBytes);
  assign ver_ok   = nib_d == 4'd4 || nib_d == 4'd6;
  assign ver_kind = nib_d == 4'd6;

  always_comb begin
    res_o.l3_kind      = pmlc_pkg::KindIpv4;
    res_o.header_bytes = '0;
    res_o.error_code   = pmlc_pkg::ErrNone;
    if (len < pmlc_pkg::OffW'(4)) begin
      res_o.error_code = pmlc_pkg::ErrRunt;
    end else if (proto_d == pmlc_pkg::ProtoMpls) begin
      if (!done_d || end_d >= len) begin
        res_o.error_code = pmlc_pkg::ErrTruncLabels;
      end else if (end_need >= len_ext || !ver_ok) begin
        res_o.error_code = pmlc_pkg::ErrNoIpMpls;
      end else begin
        res_o.l3_kind      = ver_kind;
        res_o.header_bytes = pmlc_pkg::HdrW'(end_d);
      end
    end else if (proto_d == pmlc_pkg::ProtoIpv4 || proto_d == pmlc_pkg::ProtoIpv6) begin
      if (encap_hdr_i != '0) begin
        if (t2_need >= len_ext) begin
          res_o.error_code = pmlc_pkg::ErrNoIpEncap;
        end else if (!ver_ok) begin
          res_o.error_code = pmlc_pkg::ErrBadEncapVer;
        end else begin
          res_o.l3_kind      = ver_kind;
          res_o.header_bytes = pmlc_pkg::HdrW'(t2);
        end
      end else begin
        res_o.l3_kind      = proto_d == pmlc_pkg::ProtoIpv6;
        res_o.header_bytes = pmlc_pkg::HdrW'(link_hdr_i);
      end
    end else begin
      res_o.error_code = pmlc_pkg::ErrNonIp;
    end
  end

  assign res_valid_o = advance_i && beat_i.last_byte;

  always_comb begin
    pos_d = pos_q;
    if (advance_i) begin
      if (beat_i.last_byte) begin
        pos_d = '0;
      end else if (examine) begin
        pos_d = pos_q + pmlc_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      proto_q <= '0;
      done_q  <= 1'b0;
      end_q   <= '0;
      nib_q   <= '0;
    end else begin
      pos_q <= pos_d;
      if (advance_i) begin
        if (beat_i.last_byte) begin
          proto_q <= '0;
          done_q  <= 1'b0;
          end_q   <= '0;
          nib_q   <= '0;
        end else begin
          proto_q <= proto_d;
          done_q  <= done_d;
          end_q   <= end_d;
          nib_q   <= nib_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pmlc_out_stage.sv */
// result output register
`default_nettype none

module pmlc_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               res_valid_i,
  input  wire pmlc_pkg::result_t  res_i,
  output logic                    free_o,
  pmlc_out_if.source              res_out
);

  logic              valid_q, valid_d;
  pmlc_pkg::result_t res_q;

  assign free_o = !valid_q || res_out.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (res_out.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign res_out.valid        = valid_q;
  assign res_out.l3_kind      = res_q.l3_kind;
  assign res_out.header_bytes = res_q.header_bytes;
  assign res_out.error_code   = res_q.error_code;

endmodule

`default_nettype wire

/* rtl/core/ppp_mpls_l3_classifier.sv */
// top level: ppp/mpls header classifier with config registers
// throughput: one byte beat per cycle, set by the single input register to
// result register path; a last beat waits for room in the result register,
// a new beat is taken while a result waits
// reset: asynchronous active-low clears all packet state, config returns to
// link header 4 bytes and encapsulation off
`default_nettype none

module ppp_mpls_l3_classifier (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_index_i,
  input  wire logic [pmlc_pkg::CfgW-1:0]  cfg_wdata_i,
  pmlc_in_if.sink                         pkt_in,
  pmlc_out_if.source                      res_out
);

  logic [pmlc_pkg::CfgW-1:0] link_hdr_q;
  logic [pmlc_pkg::CfgW-1:0] encap_hdr_q;

  pmlc_pkg::beat_t   beat;
  logic              beat_valid;
  logic              advance;
  logic              out_free;
  logic              res_valid;
  pmlc_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_hdr_q  <= pmlc_pkg::LinkHdrReset;
      encap_hdr_q <= pmlc_pkg::EncapHdrReset;
    end else if (cfg_we_i) begin
      unique case (pmlc_pkg::cfg_reg_e'(cfg_index_i))
        pmlc_pkg::CfgLinkHdr:  link_hdr_q  <= cfg_wdata_i;
        pmlc_pkg::CfgEncapHdr: encap_hdr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a last beat waits until the output register has room
  assign advance = beat_valid && (!beat.last_byte || out_free);

  pmlc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pkt_in       (pkt_in),
    .advance_i    (advance),
    .beat_o       (beat),
    .beat_valid_o (beat_valid)
  );

  pmlc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .beat_i      (beat),
    .link_hdr_i  (link_hdr_q),
    .encap_hdr_i (encap_hdr_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pmlc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .res_out     (res_out)
  );

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_out.valid) |-> $past(advance && beat.last_byte))
    else $error("result appeared without a last byte");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && res_out.error_code != pmlc_pkg::ErrNone
      |-> res_out.header_bytes == '0 && res_out.l3_kind == pmlc_pkg::KindIpv4)
    else $error("error result carries nonzero fields");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_valid && !advance |-> !pkt_in.ready)
    else $error("input accepted while a stalled beat is held");

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for the ppp/mpls l3 classifier: byte-level header predictor, scoreboard, random idling
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmlc_pkg::*;

  localparam bit [3:0]  IpVer4       = 4'd4;
  localparam bit [3:0]  IpVer6       = 4'd6;
  localparam bit [3:0]  IpVerBad     = 4'd5;
  localparam bit [7:0]  PppAddr      = 8'hFF;
  localparam bit [7:0]  PppCtrl      = 8'h03;
  localparam bit [15:0] ProtoLcp     = 16'hC021;

  class l3_header_board;
    bit [CfgW-1:0] link_len;
    bit [CfgW-1:0] encap_len;
    bit [PosW-1:0] pos;
    bit [15:0]     proto;
    bit            stack_done;
    bit [OffW-1:0] stack_end;
    bit [3:0]      ver;
    result_t       pending[$];
    int            mismatches;
    int            results_seen;
    int            by_err[8];

    function new();
      link_len = LinkHdrReset;
      encap_len = EncapHdrReset;
      restart();
    endfunction

    function void restart();
      pos = '0;
      proto = '0;
      stack_done = 1'b0;
      stack_end = '0;
      ver = '0;
    endfunction

    function void set_config(bit [CfgW-1:0] h, bit [CfgW-1:0] e);
      link_len = h;
      encap_len = e;
    endfunction

    function bit ver_ok();
      return ver == IpVer4 || ver == IpVer6;
    endfunction

    function void examine(int unsigned p, bit [7:0] b);
      int unsigned t2;
      bit is_mpls;
      t2 = 32'(link_len) + 32'(encap_len);
      if (p == 2 || p == 3) proto = {proto[7:0], b};
      if (!stack_done && p >= link_len && ((p - link_len) & 3) == 2 && b[0]) begin
        stack_done = 1'b1;
        stack_end = OffW'(p + 2);
      end
      is_mpls = (proto == ProtoMpls);
      if (p == t2 && (p < 4 || !is_mpls)) ver = b[7:4];
      if (stack_done && is_mpls && p >= 4 && p == stack_end) ver = b[7:4];
    endfunction

    function result_t conclude(int unsigned len);
      result_t r;
      err_e code;
      l3_kind_e kind;
      int unsigned hdr;
      int unsigned t2;
      code = ErrNone;
      kind = KindIpv4;
      hdr = 0;
      t2 = 32'(link_len) + 32'(encap_len);
      if (len < 4) begin
        code = ErrRunt;
      end else if (proto == ProtoMpls) begin
        if (!stack_done || stack_end >= len) begin
          code = ErrTruncLabels;
        end else if (stack_end + IpHdrBytes >= len || !ver_ok()) begin
          code = ErrNoIpMpls;
        end else begin
          hdr = 32'(stack_end);
          kind = (ver == IpVer6) ? KindIpv6 : KindIpv4;
        end
      end else if (proto == ProtoIpv4 || proto == ProtoIpv6) begin
        kind = (proto == ProtoIpv6) ? KindIpv6 : KindIpv4;
        if (encap_len != 0) begin
          if (t2 + IpHdrBytes >= len) begin
            code = ErrNoIpEncap;
          end else if (!ver_ok()) begin
            code = ErrBadEncapVer;
          end else begin
            hdr = t2;
            kind = (ver == IpVer6) ? KindIpv6 : KindIpv4;
          end
        end else begin
          hdr = 32'(link_len);
        end
      end else begin
        code = ErrNonIp;
      end
      if (code != ErrNone) begin
        kind = KindIpv4;
        hdr = 0;
      end
      r.l3_kind = kind;
      r.header_bytes = hdr[HdrW-1:0];
      r.error_code = code;
      return r;
    endfunction

    function void take_beat(bit [7:0] b, bit last);
      int unsigned p;
      p = 32'(pos);
      if (p < PosMax) examine(p, b);
      if (last) begin
        pending.push_back(conclude(p + 1));
        restart();
      end else if (p < PosMax) begin
        pos = pos + 1'b1;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending (err %0d hdr %0d)",
                         got.error_code, got.header_bytes));
        return;
      end
      want = pending.pop_front();
      results_seen++;
      by_err[got.error_code]++;
      if (got.l3_kind !== want.l3_kind)
        report($sformatf("result %0d l3_kind got %0d want %0d",
                         results_seen, got.l3_kind, want.l3_kind));
      if (got.header_bytes !== want.header_bytes)
        report($sformatf("result %0d header_bytes got %0d want %0d",
                         results_seen, got.header_bytes, want.header_bytes));
      if (got.error_code !== want.error_code)
        report($sformatf("result %0d error_code got %0d want %0d",
                         results_seen, got.error_code, want.error_code));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;

  pmlc_in_if  pkt_if ();
  pmlc_out_if res_if ();

  ppp_mpls_l3_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pkt_in      (pkt_if),
    .res_out     (res_if)
  );

  l3_header_board board = new();

  bit [7:0] pkt[$];
  int gap_pct;
  int stall_pct;
  int pkts_sent;
  int bytes_sent;
  int cfg_count;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pkt_if.valid && pkt_if.ready)
      board.take_beat(pkt_if.data_byte, pkt_if.last_byte);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      board.check_result(result_t'{res_if.l3_kind, res_if.header_bytes, res_if.error_code});
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function void put(int unsigned off, bit [7:0] v);
    while (pkt.size() <= off) pkt.push_back(8'($urandom_range(255)));
    pkt[off] = v;
  endfunction

  function void stamp(bit [15:0] p);
    put(0, PppAddr);
    put(1, PppCtrl);
    put(2, p[15:8]);
    put(3, p[7:0]);
  endfunction

  function bit [3:0] pick_ver();
    if ($urandom_range(99) < 85) return $urandom_range(1) ? IpVer6 : IpVer4;
    return 4'($urandom_range(15));
  endfunction

  function int unsigned pick_tail();
    return ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
  endfunction

  // labels first, protocol bytes stamped last so short link headers still read as mpls
  function void make_mpls(int unsigned nlab, bit [3:0] v, int unsigned tail);
    int unsigned o;
    pkt.delete();
    for (int unsigned k = 0; k < nlab; k++) begin
      o = board.link_len + LabelBytes * k;
      put(o, 8'($urandom_range(255)));
      put(o + 1, 8'($urandom_range(255)));
      put(o + 2, {7'($urandom_range(127)), k == nlab - 1});
      put(o + 3, 8'($urandom_range(255)));
    end
    o = board.link_len + LabelBytes * nlab;
    put(o, {v, 4'($urandom_range(15))});
    put(o + IpHdrBytes + tail, 8'($urandom_range(255)));
    stamp(ProtoMpls);
  endfunction

  function void make_ip(bit [15:0] p, bit [3:0] v, int unsigned tail);
    int unsigned t2;
    t2 = 32'(board.link_len) + 32'(board.encap_len);
    pkt.delete();
    if (board.encap_len != 0) begin
      put(t2, {v, 4'($urandom_range(15))});
      put(t2 + IpHdrBytes + tail, 8'($urandom_range(255)));
    end else begin
      put($urandom_range(3, board.link_len + 24), 8'($urandom_range(255)));
      if (board.link_len < pkt.size()) pkt[board.link_len] = {v, 4'($urandom_range(15))};
    end
    stamp(p);
  endfunction

  function void strip_bos();
    for (int unsigned p = board.link_len + 2; p < pkt.size(); p += LabelBytes) pkt[p][0] = 1'b0;
  endfunction

  function void cut_to(int unsigned len);
    while (pkt.size() > len) void'(pkt.pop_back());
  endfunction

  function void random_packet();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 32) begin
      make_mpls($urandom_range(1, 3), pick_ver(), pick_tail());
    end else if (r < 62) begin
      make_ip($urandom_range(1) ? ProtoIpv6 : ProtoIpv4, pick_ver(), pick_tail());
    end else if (r < 72) begin
      if ($urandom_range(1)) make_mpls($urandom_range(1, 3), pick_ver(), pick_tail());
      else make_ip($urandom_range(1) ? ProtoIpv6 : ProtoIpv4, pick_ver(), pick_tail());
      cut_to($urandom_range(1, pkt.size()));
    end else if (r < 78) begin
      make_mpls($urandom_range(1, 3), pick_ver(), pick_tail());
      strip_bos();
    end else if (r < 86) begin
      pkt.delete();
      put($urandom_range(3, 30), 8'($urandom_range(255)));
      stamp(16'($urandom_range(16'hFFFF)));
    end else if (r < 92) begin
      pkt.delete();
      put($urandom_range(0, 2), 8'($urandom_range(255)));
    end else begin
      pkt.delete();
      put($urandom_range(0, 40), 8'($urandom_range(255)));
    end
  endfunction

  task automatic push_byte(bit [7:0] b, bit last);
    while ($urandom_range(99) < gap_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_if.valid <= 1'b1;
    pkt_if.data_byte <= b;
    pkt_if.last_byte <= last;
    do @(posedge clk_i); while (!pkt_if.ready);
  endtask

  task automatic send_packet();
    for (int unsigned i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
    pkts_sent++;
    bytes_sent += pkt.size();
  endtask

  task automatic wait_results();
    pkt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(bit [CfgW-1:0] h, bit [CfgW-1:0] e);
    wait_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgLinkHdr;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= CfgEncapHdr;
    cfg_wdata_i <= e;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_config(h, e);
    cfg_count++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin
        gap_pct = 54;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 54;
      end
      3: begin
        gap_pct = 27;
        stall_pct = 27;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic directed();
    for (int unsigned i = 1; i <= 3; i++) begin
      pkt.delete();
      put(i - 1, 8'($urandom_range(255)));
      send_packet();
    end
    pkt.delete();
    stamp(ProtoLcp);
    send_packet();
    // plain ipv4 whose header runs past the end
    pkt.delete();
    stamp(ProtoIpv4);
    send_packet();
    make_ip(ProtoIpv6, IpVer6, 0);
    send_packet();
    make_mpls(1, IpVer4, 0);
    send_packet();
    make_mpls(2, IpVer6, 0);
    void'(pkt.pop_back());
    send_packet();
    make_mpls(3, IpVer4, 4);
    strip_bos();
    send_packet();
    make_mpls(2, IpVer4, 0);
    cut_to(board.link_len + LabelBytes + 3);
    send_packet();
    make_mpls(1, IpVerBad, 2);
    send_packet();
    pkt.delete();
    repeat (8) pkt.push_back(8'hFF);
    send_packet();
    pkt.delete();
    repeat (8) pkt.push_back(8'h00);
    send_packet();

    reconfigure(8'd4, 8'd3);
    make_ip(ProtoIpv4, IpVer4, 0);
    send_packet();
    make_ip(ProtoIpv6, IpVer4, 3);
    send_packet();
    make_ip(ProtoIpv4, IpVer6, 0);
    void'(pkt.pop_back());
    send_packet();
    make_ip(ProtoIpv6, IpVerBad, 1);
    send_packet();
    make_mpls(1, IpVer6, 1);
    send_packet();

    // version byte inside the protocol field
    reconfigure(8'd0, 8'd2);
    make_ip(ProtoIpv4, IpVer4, 3);
    send_packet();
    // label stack overlapping the protocol bytes
    reconfigure(8'd1, 8'd0);
    make_mpls(2, IpVer4, 0);
    send_packet();

    // largest header registers on short packets
    reconfigure(8'd255, 8'd0);
    pkt.delete();
    stamp(ProtoIpv6);
    send_packet();
    reconfigure(8'd255, 8'd255);
    pkt.delete();
    stamp(ProtoIpv4);
    send_packet();
    pkt.delete();
    put(1, 8'($urandom_range(255)));
    send_packet();
  endtask

  task automatic run_phase(bit [CfgW-1:0] h, bit [CfgW-1:0] e, int mode);
    int n;
    int nbytes;
    reconfigure(h, e);
    set_idling(mode);
    n = 0;
    nbytes = 0;
    while (n < 2 || nbytes < 36) begin
      random_packet();
      send_packet();
      n++;
      nbytes += pkt.size();
      if (n == 2) wait_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgLinkHdr;
    cfg_wdata_i = '0;
    pkt_if.valid = 1'b0;
    pkt_if.data_byte = '0;
    pkt_if.last_byte = 1'b0;
    res_if.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();

    run_phase(8'd4, 8'd0, 0);
    run_phase(8'd0, 8'd0, 1);
    run_phase(8'd9, 8'd5, 2);
    run_phase(8'd2, 8'd6, 3);
    run_phase(8'd3, 8'd1, 1);

    wait_results();
    repeat (8) @(posedge clk_i);

    $display("sent %0d packets (%0d bytes) under %0d register settings, four idling modes",
             pkts_sent, bytes_sent, cfg_count);
    $display("results by code: ok %0d non-ip %0d labels %0d mpls %0d encap %0d ver %0d runt %0d",
             board.by_err[ErrNone], board.by_err[ErrNonIp], board.by_err[ErrTruncLabels],
             board.by_err[ErrNoIpMpls], board.by_err[ErrNoIpEncap],
             board.by_err[ErrBadEncapVer], board.by_err[ErrRunt]);
    if (board.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", board.pending.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pmlc_pkg.sv
rtl/core/pmlc_if.sv
rtl/core/pmlc_in_stage.sv
rtl/core/pmlc_parse.sv
rtl/core/pmlc_out_stage.sv
rtl/core/ppp_mpls_l3_classifier.sv
test/tb.sv
